>>> sv/dmhs_pkg.sv
package dmhs_pkg;

	// Table geometry and key length.
	localparam int TABLE_SIZE = 101;
	localparam int KEY_BYTES  = 4;

	localparam int SLOT_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int BYTE_CNT_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	// Width of the slot field on the result channel.
	localparam int SLOT_OUT_W = 7;

	localparam logic [31:0] HASH_MULT = 32'd37;

	// floor(2^32 / TABLE_SIZE); the quotient estimate built from it is low by at most one.
	localparam logic [31:0] HASH_RECIP = 32'((64'd1 << 32) / TABLE_SIZE);

	localparam logic [31:0] TABLE_SIZE_W = 32'(TABLE_SIZE);

	// Command codes.
	localparam logic CMD_PUT = 1'b0;
	localparam logic CMD_GET = 1'b1;

endpackage

>>> sv/direct_mapped_hash_store.sv
// Direct-mapped key/value store with a multiplicative byte hash.
// Request channel: req_valid, req_stall, command, key and value. A beat is
// taken at a rising edge where req_valid is high and req_stall is low. A put
// (command 0) overwrites the slot's key and value; a get (command 1) returns
// the slot's value when the stored key equals the query key, and zero if not.
// Result channel: rsp_valid, rsp_stall, slot, read_value, key_matched and
// put_count, one result beat for every request beat, in order.
//
// Timing: the hash walks one key byte per cycle in HASH, then the multiply
// states MUL and MUL2 form a quotient estimate, SUB reduces the hash modulo
// the table size and issues the memory read, and LOOK compares and writes
// back. The result is registered as LOOK finishes, and a new request is
// taken only once the sequencer is back in IDLE, so one item is in flight
// at a time. The single hash unit and the read-modify-write of the slot
// memory set this limit.
// Reset clears the state machine, the put counter and one valid bit per slot;
// a slot whose valid bit is clear reads as key 0 and value 0. When the
// receiver stalls, the result stays in the output register and the next
// request is still hashed, but it is held before write-back until the
// pending result beat has been taken.
module direct_mapped_hash_store
	import dmhs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic                     command,
	input  logic [31:0]              key,
	input  logic signed [31:0]       value,

	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [SLOT_OUT_W-1:0]    slot,
	output logic signed [31:0]       read_value,
	output logic                     key_matched,
	output logic [31:0]              put_count
);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HASH = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_SUB  = 3'd4;
	localparam logic [2:0] ST_LOOK = 3'd5;

	logic [2:0]            state_q;
	logic [BYTE_CNT_W-1:0] byte_cnt_q;

	// Item registers.
	logic                  cmd_q;
	logic [31:0]           key_q;
	logic [31:0]           val_q;
	logic [31:0]           key_shift_q;
	logic [31:0]           hash_q;
	logic [63:0]           recip_prod_q;
	logic [31:0]           quot_prod_q;
	logic [SLOT_W-1:0]     slot_q;

	logic [31:0]           put_cnt_q;

	// Slot memories; the valid bits stand in for the reset contents.
	logic [31:0]           key_mem [TABLE_SIZE];
	logic [31:0]           val_mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] valid_q;
	logic [31:0]           rd_key_q;
	logic [31:0]           rd_val_q;
	logic                  rd_valid_q;

	// Output register.
	logic                  rsp_valid_q;
	logic [SLOT_OUT_W-1:0] rsp_slot_q;
	logic [31:0]           rsp_value_q;
	logic                  rsp_match_q;
	logic [31:0]           rsp_count_q;

	logic                  req_take;
	logic                  out_free;
	logic                  finish;
	logic [7:0]            cur_byte;
	logic [31:0]           hash_next;
	logic [31:0]           rem_raw;
	logic [31:0]           rem_fix;
	logic [SLOT_W-1:0]     slot_calc;
	logic [31:0]           stored_key;
	logic [31:0]           stored_val;
	logic                  hit;
	logic [31:0]           put_cnt_next;
	logic [31:0]           slot_wide;

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign finish    = (state_q == ST_LOOK) && out_free;

	// One hash step: h = 37 * h + sign-extended byte, wrapping at 32 bits.
	assign cur_byte  = key_shift_q[7:0];
	assign hash_next = hash_q * HASH_MULT + {{24{cur_byte[7]}}, cur_byte};

	// Remainder from the quotient estimate lies below twice the table size.
	assign rem_raw   = hash_q - quot_prod_q;
	assign rem_fix   = (rem_raw >= TABLE_SIZE_W) ? (rem_raw - TABLE_SIZE_W) : rem_raw;
	assign slot_calc = rem_fix[SLOT_W-1:0];

	assign stored_key = rd_valid_q ? rd_key_q : 32'd0;
	assign stored_val = rd_valid_q ? rd_val_q : 32'd0;
	assign hit        = (cmd_q == CMD_GET) && (stored_key == key_q);

	assign put_cnt_next = (put_cnt_q == 32'hFFFF_FFFF) ? put_cnt_q : (put_cnt_q + 32'd1);
	assign slot_wide    = 32'(slot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			byte_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						state_q    <= ST_HASH;
						byte_cnt_q <= '0;
					end
				end
				ST_HASH: begin
					byte_cnt_q <= byte_cnt_q + 1'b1;
					if (byte_cnt_q == BYTE_CNT_W'(KEY_BYTES - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_SUB;
				ST_SUB:  state_q <= ST_LOOK;
				ST_LOOK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers follow the sequencer.
	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_q       <= command;
			key_q       <= key;
			val_q       <= value;
			key_shift_q <= key;
			hash_q      <= '0;
		end
		if (state_q == ST_HASH) begin
			hash_q      <= hash_next;
			key_shift_q <= {8'd0, key_shift_q[31:8]};
		end
		if (state_q == ST_MUL) begin
			recip_prod_q <= hash_q * {32'd0, HASH_RECIP};
		end
		if (state_q == ST_MUL2) begin
			quot_prod_q <= recip_prod_q[63:32] * TABLE_SIZE_W;
		end
		if (state_q == ST_SUB) begin
			slot_q <= slot_calc;
		end
	end

	// Slot memory: read issued with the slot, write-back for puts.
	always_ff @(posedge clk) begin
		if (state_q == ST_SUB) begin
			rd_key_q   <= key_mem[slot_calc];
			rd_val_q   <= val_mem[slot_calc];
			rd_valid_q <= valid_q[slot_calc];
		end
		if (finish && (cmd_q == CMD_PUT)) begin
			key_mem[slot_q] <= key_q;
			val_mem[slot_q] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			put_cnt_q <= '0;
		end else if (finish && (cmd_q == CMD_PUT)) begin
			valid_q[slot_q] <= 1'b1;
			put_cnt_q       <= put_cnt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_slot_q  <= slot_wide[SLOT_OUT_W-1:0];
			rsp_value_q <= hit ? stored_val : 32'd0;
			rsp_match_q <= hit;
			rsp_count_q <= (cmd_q == CMD_PUT) ? put_cnt_next : put_cnt_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign slot        = rsp_slot_q;
	assign read_value  = rsp_value_q;
	assign key_matched = rsp_match_q;
	assign put_count   = rsp_count_q;

	// A taken request always starts the hash walk.
	a_take_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> (state_q == ST_HASH))
		else $error("request taken but hash did not start");

	// The reduced slot always addresses a real table entry.
	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> (32'(slot_q) < TABLE_SIZE_W))
		else $error("slot out of table range");

	// The put counter never moves backward.
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (put_cnt_q >= $past(put_cnt_q)))
		else $error("put counter decreased");

	// A result without a key match carries a zero value.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !key_matched) |-> (read_value == 32'sd0))
		else $error("nonzero value on a miss");

	// A pending result is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !finish)
		else $error("pending result overwritten");

endmodule

>>> test/direct_mapped_hash_store_tb.sv
`timescale 1ns / 100ps

module direct_mapped_hash_store_tb;
	import dmhs_pkg::*;

	// One result beat as the checker sees it.
	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic signed [31:0]    read_value;
		logic                  key_matched;
		logic [31:0]           put_count;
	} lookup_result_t;

	// One row of the directed table. When typed is set, want is the result
	// written out by hand; otherwise the predictor supplies the result.
	typedef struct packed {
		logic           command;
		logic [31:0]    key;
		logic [31:0]    value;
		logic           typed;
		lookup_result_t want;
	} request_row_t;

	localparam int ROWS         = 20;
	localparam int RANDOM_ITEMS = 1080;
	localparam int POOL_SIZE    = 48;
	localparam int HOLD_CYCLES  = 80;
	// Extra wait after the last owed result, to catch stray result beats.
	localparam int DRAIN_CYCLES = 4 * (KEY_BYTES + 5);
	localparam int QUIET_LIMIT  = 1000;

	// Key 0 hashes to slot 0, so those rows can be read off directly. Key
	// 0x3138 also lands in slot 0 (bytes 0x38 and 0x31 cancel modulo 101),
	// which lets the table show one put evicting another.
	localparam request_row_t DIRECTED_ROWS [ROWS] = '{
		// Empty table: a get of key 0 matches the cleared slot and returns 0.
		'{CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{7'd0, 32'sd0, 1'b1, 32'd0}},
		'{CMD_GET, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0},
		'{CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		// Largest positive value, then read back with a junk value field.
		'{CMD_PUT, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, '{7'd0, 32'sd0, 1'b0, 32'd1}},
		'{CMD_GET, 32'h0000_0000, 32'h5A5A_5A5A, 1'b1,
			'{7'd0, 32'sh7FFF_FFFF, 1'b1, 32'd1}},
		// Most negative value overwrites the same slot.
		'{CMD_PUT, 32'h0000_0000, 32'h8000_0000, 1'b1, '{7'd0, 32'sd0, 1'b0, 32'd2}},
		'{CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1,
			'{7'd0, 32'sh8000_0000, 1'b1, 32'd2}},
		// All-ones key: every byte sign-extends to -1.
		'{CMD_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
		'{CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
		'{CMD_GET, 32'hFFFF_FFFE, 32'h0000_0000, 1'b0, '0},
		// Low byte with only its sign bit set.
		'{CMD_PUT, 32'h0000_0080, 32'h0000_0001, 1'b0, '0},
		'{CMD_GET, 32'h0000_0080, 32'h0000_0000, 1'b0, '0},
		'{CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
		'{CMD_PUT, 32'h7F7F_7F7F, 32'h1234_5678, 1'b0, '0},
		'{CMD_GET, 32'h7F7F_7F7F, 32'h0000_0000, 1'b0, '0},
		'{CMD_PUT, 32'h8080_8080, 32'hA5A5_A5A5, 1'b0, '0},
		'{CMD_GET, 32'h8080_8080, 32'h0000_0000, 1'b0, '0},
		// Collision: key 0x3138 evicts key 0 from slot 0.
		'{CMD_PUT, 32'h0000_3138, 32'h0000_BEEF, 1'b1, '{7'd0, 32'sd0, 1'b0, 32'd7}},
		'{CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, '{7'd0, 32'sd0, 1'b0, 32'd7}},
		'{CMD_GET, 32'h0000_3138, 32'h0000_0000, 1'b1,
			'{7'd0, 32'sh0000_BEEF, 1'b1, 32'd7}}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	logic                  command;
	logic [31:0]           key;
	logic signed [31:0]    value;
	logic                  rsp_valid;
	logic                  rsp_stall;
	logic [SLOT_OUT_W-1:0] slot;
	logic signed [31:0]    read_value;
	logic                  key_matched;
	logic [31:0]           put_count;

	// Predictor state: our own copy of the table and the put counter.
	logic [31:0] model_keys [TABLE_SIZE];
	logic [31:0] model_values [TABLE_SIZE];
	logic [31:0] model_puts;

	// Results still owed by the block, oldest first.
	lookup_result_t pending_lookups [$];

	int   failures = 0;
	int   quiet_cycles = 0;
	logic calm = 1'b0;     // both sides stop idling while this is set
	logic hold_req = 1'b0; // asks the receiver for one long hold-off

	direct_mapped_hash_store dut (
		.clk, .arst_n,
		.req_valid, .req_stall, .command, .key, .value,
		.rsp_valid, .rsp_stall, .slot, .read_value, .key_matched, .put_count
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hash the key bytes least significant first, each byte sign-extended,
	// with a 32-bit wrapping multiply-add, then reduce modulo the table size.
	// Bytes past the 32-bit key read as zero.
	function automatic logic [31:0] hash_slot(input logic [31:0] k);
		logic [31:0] h;
		logic [7:0]  b;
		h = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			b = 8'(k >> (8 * i));
			h = h * HASH_MULT + {{24{b[7]}}, b};
		end
		return h % TABLE_SIZE_W;
	endfunction

	// Apply one request to the predictor and return the result it causes.
	function automatic lookup_result_t lookup_or_store(input logic cmd, input logic [31:0] k,
			input logic [31:0] v);
		lookup_result_t r;
		logic [31:0]    s;
		s = hash_slot(k);
		r = '0;
		r.slot = s[SLOT_OUT_W-1:0];
		if (cmd == CMD_GET) begin
			if (model_keys[s] == k) begin
				r.read_value = model_values[s];
				r.key_matched = 1'b1;
			end
		end else begin
			model_keys[s] = k;
			model_values[s] = v;
			if (model_puts != 32'hFFFF_FFFF)
				model_puts++;
		end
		r.put_count = model_puts;
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, what, want, got);
			failures++;
		end
	endfunction

	// Offer one request beat. Called at a falling edge and returns at the
	// falling edge after the beat was taken, so the next call can change the
	// payload without lowering valid in between. The prediction is made at
	// the accepting edge, which keeps it in step with the block's own order.
	task automatic issue_request(input logic cmd, input logic [31:0] k, input logic [31:0] v,
			input logic typed, input lookup_result_t want);
		int             gap;
		lookup_result_t predicted;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 32)
				gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command <= cmd;
		key <= k;
		value <= v;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		predicted = lookup_or_store(cmd, k, v);
		pending_lookups.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	// Every accepted result beat is matched against the oldest expectation.
	always @(posedge clk) begin : result_check
		lookup_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_lookups.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual slot %0d value 0x%h",
					$time, slot, read_value);
				failures++;
			end else begin
				want = pending_lookups.pop_front();
				check_field("slot", 32'(want.slot), 32'(slot));
				check_field("read_value", want.read_value, read_value);
				check_field("key_matched", 32'(want.key_matched), 32'(key_matched));
				check_field("put_count", want.put_count, put_count);
			end
		end
	end

	// Watchdog: a run that stops moving beats on both channels is a hang.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, no beat for %0d cycles", $time, quiet_cycles);
			$display("FAIL direct_mapped_hash_store");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side. Stalls at random about a third of the time, not at all
	// while calm is set, and on request holds off for a long stretch so that
	// the block backs up and has to stall the request side.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (calm) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < 32);
			end
		end
	end

	initial begin : stimulus
		logic [31:0] key_pool [POOL_SIZE];
		logic [31:0] k;
		logic [31:0] v;
		logic        cmd;
		int          pick;
		int          idx;

		req_valid = 1'b0;
		command = CMD_PUT;
		key = '0;
		value = '0;
		arst_n = 1'b0;
		model_puts = '0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			model_keys[i] = '0;
			model_values[i] = '0;
		end

		// The random part works mostly on a pool of keys, so that gets find
		// what earlier puts left and keys sharing a slot evict each other.
		// A third of the pool are single-byte keys to vary the low byte.
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = (i % 3 == 0) ? 32'($urandom_range(255)) : $urandom;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'h0000_3138;
		key_pool[2] = 32'hFFFF_FFFF;
		key_pool[4] = 32'h8080_8080;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED_ROWS[r])
			issue_request(DIRECTED_ROWS[r].command, DIRECTED_ROWS[r].key,
				DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Two long receiver hold-offs, and one stretch with no idling.
			if (n == 150 || n == 700)
				hold_req = 1'b1;
			calm = (n >= 450 && n < 600);

			if ($urandom_range(99) < 3)
				key_pool[$urandom_range(POOL_SIZE - 1)] = $urandom;

			idx = $urandom_range(POOL_SIZE - 1);
			pick = $urandom_range(99);
			if (pick < 40) begin
				cmd = CMD_PUT;
				k = key_pool[idx];
			end else if (pick < 85) begin
				cmd = CMD_GET;
				k = key_pool[idx];
			end else if (pick < 93) begin
				cmd = CMD_GET;
				k = $urandom;
			end else begin
				cmd = CMD_PUT;
				k = $urandom;
			end

			case ($urandom_range(19))
				0:       v = 32'h7FFF_FFFF;
				1:       v = 32'h8000_0000;
				2:       v = 32'h0000_0000;
				default: v = $urandom;
			endcase

			issue_request(cmd, k, v, 1'b0, '0);
		end
		req_valid <= 1'b0;
		calm = 1'b0;

		// Wait for every owed result, then a little longer to catch strays.
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("PASS direct_mapped_hash_store");
		else
			$display("FAIL direct_mapped_hash_store");
		$finish;
	end

endmodule

>>> direct_mapped_hash_store.f
sv/dmhs_pkg.sv
sv/direct_mapped_hash_store.sv
test/direct_mapped_hash_store_tb.sv
